FILE: rtl/core/sppc_pkg.sv
package sppc_pkg;

	// command codes carried by the command field
	typedef enum logic [2:0] {
		CMD_PULSE_DONE = 3'd0,
		CMD_POLL       = 3'd1,
		CMD_START_MOVE = 3'd2,
		CMD_START_REVS = 3'd3,
		CMD_STOP       = 3'd4,
		CMD_ZERO       = 3'd5,
		CMD_TRACKING   = 3'd6,
		CMD_TARGET     = 3'd7
	} cmd_t;

	localparam int unsigned POS_W = 32;
	localparam int unsigned CNT_W = 32;

	// goal used for open-ended tracking moves
	localparam logic [CNT_W-1:0] OPEN_GOAL = {CNT_W{1'b1}};

endpackage

FILE: rtl/core/stepper_pulse_position_controller.sv
// step/direction pulse controller
//
// input channel (in_valid / in_ready) carries one command beat: pulse done,
// tracking poll, start move of N pulses, start move of N revolutions, stop,
// zero position, tracking enable/disable, or set target
// output channel (out_valid / out_ready) returns exactly one result beat per
// command: accepted flag, running, dir_pin, stopped_now, position,
// target_out, move_progress and tracking_on as they stand after the command
//
// latency: the result beat is valid in the cycle after the command is taken
// throughput: one command per cycle while results are drained; the whole
// update is one pass of compare, increment and a single multiply
// (revolutions, 32 x 12 bits at the default 3200 pulses per revolution) into
// the state and result registers
// in_ready stays high while the result register is empty or being drained,
// so a stalled receiver holds the current result and blocks only the next
// command, never loses or repeats one
// reset (arst_n low) clears position, target, progress, goal, direction,
// busy, stop request and tracking mode, and empties the result register
module stepper_pulse_position_controller
	import sppc_pkg::*;
#(
	parameter int unsigned PULSES_PER_REV = 3200
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              command,
	input  logic                    move_dir,
	input  logic [CNT_W-1:0]        amount,
	input  logic                    enable_flag,
	input  logic signed [POS_W-1:0] new_target,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    accepted,
	output logic                    running,
	output logic                    dir_pin,
	output logic                    stopped_now,
	output logic signed [POS_W-1:0] position,
	output logic signed [POS_W-1:0] target_out,
	output logic [CNT_W-1:0]        move_progress,
	output logic                    tracking_on
);

	// width of the pulses-per-revolution constant, enough for its full range
	localparam int unsigned PPR_W = $clog2(PULSES_PER_REV + 1);
	localparam int unsigned PROD_W = CNT_W + PPR_W;
	localparam logic [PPR_W-1:0] PPR = PPR_W'(PULSES_PER_REV);
	// largest revolution count whose pulse total still fits the counter
	localparam logic [CNT_W-1:0] REV_LIMIT = CNT_W'(32'hFFFF_FFFF / PULSES_PER_REV);

	// controller state
	logic [CNT_W-1:0]        move_goal_q;
	logic [CNT_W-1:0]        move_done_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] goal_pos_q;
	logic                    dir_q;
	logic                    busy_q;
	logic                    stop_pend_q;
	logic                    track_q;

	// result-only fields and output slot
	logic out_valid_q;
	logic acc_q;
	logic ended_q;

	// next-state values
	logic [CNT_W-1:0]        move_goal_d;
	logic [CNT_W-1:0]        move_done_d;
	logic signed [POS_W-1:0] pos_d;
	logic signed [POS_W-1:0] goal_pos_d;
	logic                    dir_d;
	logic                    busy_d;
	logic                    stop_pend_d;
	logic                    track_d;
	logic                    acc_d;
	logic                    ended_d;

	logic                    in_fire;
	logic [PROD_W-1:0]       rev_prod;
	logic signed [POS_W-1:0] pos_step;
	logic [CNT_W-1:0]        done_inc;
	logic                    reached;
	cmd_t                    cmd;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign cmd      = cmd_t'(command);

	assign rev_prod = {{PPR_W{1'b0}}, amount} * {{CNT_W{1'b0}}, PPR};
	assign pos_step = dir_q ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
	assign done_inc = move_done_q + CNT_W'(1);

	// tracking arrival test on the position after this pulse
	always_comb begin
		if (!track_q) begin
			reached = 1'b0;
		end else if (!dir_q) begin
			reached = !(pos_step < goal_pos_q);
		end else begin
			reached = !(goal_pos_q < pos_step);
		end
	end

	always_comb begin
		move_goal_d = move_goal_q;
		move_done_d = move_done_q;
		pos_d       = pos_q;
		goal_pos_d  = goal_pos_q;
		dir_d       = dir_q;
		busy_d      = busy_q;
		stop_pend_d = stop_pend_q;
		track_d     = track_q;
		acc_d       = 1'b0;
		ended_d     = 1'b0;
		unique case (cmd)
			CMD_PULSE_DONE: begin
				if (busy_q) begin
					acc_d       = 1'b1;
					move_done_d = done_inc;
					pos_d       = pos_step;
					if (stop_pend_q || reached || (!track_q && done_inc >= move_goal_q)) begin
						busy_d      = 1'b0;
						stop_pend_d = 1'b0;
						ended_d     = 1'b1;
					end
				end
			end
			CMD_POLL: begin
				if (track_q) begin
					acc_d = 1'b1;
					if (busy_q) begin
						if (pos_q == goal_pos_q ||
						    (!dir_q && goal_pos_q < pos_q) ||
						    (dir_q && pos_q < goal_pos_q)) begin
							stop_pend_d = 1'b1;
						end
					end else if (pos_q != goal_pos_q) begin
						// open-ended move toward the target
						dir_d       = !(pos_q < goal_pos_q);
						move_goal_d = OPEN_GOAL;
						move_done_d = '0;
						busy_d      = 1'b1;
						stop_pend_d = 1'b0;
					end
				end
			end
			CMD_START_MOVE, CMD_START_REVS: begin
				if (amount != '0 && !busy_q &&
				    (cmd == CMD_START_MOVE || amount <= REV_LIMIT)) begin
					acc_d       = 1'b1;
					track_d     = 1'b0;
					goal_pos_d  = pos_q;
					dir_d       = move_dir;
					move_goal_d = (cmd == CMD_START_MOVE) ? amount : rev_prod[CNT_W-1:0];
					move_done_d = '0;
					busy_d      = 1'b1;
					stop_pend_d = 1'b0;
				end
			end
			CMD_STOP: begin
				acc_d = 1'b1;
				if (busy_q) begin
					stop_pend_d = 1'b1;
				end
			end
			CMD_ZERO: begin
				if (!busy_q && !track_q) begin
					acc_d      = 1'b1;
					pos_d      = '0;
					goal_pos_d = '0;
				end
			end
			CMD_TRACKING: begin
				if (!enable_flag) begin
					acc_d      = 1'b1;
					track_d    = 1'b0;
					goal_pos_d = pos_q;
					if (busy_q) begin
						stop_pend_d = 1'b1;
					end
				end else if (!busy_q) begin
					acc_d      = 1'b1;
					track_d    = 1'b1;
					goal_pos_d = pos_q;
				end
			end
			CMD_TARGET: begin
				if (track_q) begin
					acc_d      = 1'b1;
					goal_pos_d = new_target;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_goal_q <= '0;
			move_done_q <= '0;
			pos_q       <= '0;
			goal_pos_q  <= '0;
			dir_q       <= 1'b0;
			busy_q      <= 1'b0;
			stop_pend_q <= 1'b0;
			track_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				move_goal_q <= move_goal_d;
				move_done_q <= move_done_d;
				pos_q       <= pos_d;
				goal_pos_q  <= goal_pos_d;
				dir_q       <= dir_d;
				busy_q      <= busy_d;
				stop_pend_q <= stop_pend_d;
				track_q     <= track_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result-only payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q   <= acc_d;
			ended_q <= ended_d;
		end
	end

	// state only moves on a taken command, which also refills the output slot,
	// so it doubles as the result payload
	assign out_valid     = out_valid_q;
	assign accepted      = acc_q;
	assign stopped_now   = ended_q;
	assign running       = busy_q;
	assign dir_pin       = dir_q;
	assign position      = pos_q;
	assign target_out    = goal_pos_q;
	assign move_progress = move_done_q;
	assign tracking_on   = track_q;

endmodule

FILE: rtl/core/sppc_checker.sv
module sppc_checker
	import sppc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    accepted,
	input logic                    running,
	input logic                    stopped_now,
	input logic signed [POS_W-1:0] position
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its position
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position))
		else $error("result payload changed while stalled");

	// every taken command yields a result beat in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("command without result beat");

	// a move that ended is no longer running and its last pulse was accepted
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped_now |-> !running && accepted)
		else $error("ended move still running");

	// no room for a command while a result is stuck
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("command taken over a stalled result");

endmodule

bind stepper_pulse_position_controller sppc_checker u_sppc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.accepted    (accepted),
	.running     (running),
	.stopped_now (stopped_now),
	.position    (position)
);
